// File: src/nctd_pkg.sv
// nctd_pkg: shared constants, types and helpers for the nmea coordinate converter
// used by nctd_front, nctd_queue, nctd_back and nmea_coordinate_to_degrees
// no dependencies
package nctd_pkg;

  localparam int MAX_INT_DIGITS  = 5;
  localparam int MAX_FRAC_DIGITS = 7;
  localparam int FRAC_BITS       = 24;
  localparam int MIN_INT_DIGITS  = 2;

  localparam int OUT_W   = 35;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int MIN_W   = 7;

  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SOUTH = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_WEST  = 8'h57;

  localparam longint unsigned MINS_PER_DEG = 64'd60;
  localparam longint unsigned POS_LIMIT    = (64'd1 << (OUT_W - 1)) - 64'd1;
  localparam longint unsigned NEG_LIMIT    = 64'd1 << (OUT_W - 1);

  // elaboration-time power of ten, also folded when called with a constant
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam int DEG_W      = $clog2(pow10(MAX_INT_DIGITS - MIN_INT_DIGITS));
  localparam int FRAC_ACC_W = $clog2(pow10(MAX_FRAC_DIGITS));
  localparam int ICNT_W     = $clog2(MAX_INT_DIGITS + 1);
  localparam int FCNT_W     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int NUM_W      = $clog2(64'd100 * pow10(MAX_FRAC_DIGITS));
  localparam int DEN_W      = $clog2(MINS_PER_DEG * pow10(MAX_FRAC_DIGITS) + 64'd1);
  localparam int ITER_W     = $clog2(FRAC_BITS);
  localparam int MAG_W      = DEG_W + 2 + FRAC_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_POINT  = 2'd1,
    ST_FEW_DIGITS = 2'd2,
    ST_MALFORMED = 2'd3
  } nctd_status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SETUP,
    BK_DIVIDE,
    BK_ROUND,
    BK_FINISH
  } nctd_bk_state_e;

  // one finished coordinate text, classified
  typedef struct packed {
    nctd_status_e            status;
    logic                    neg;
    logic [DEG_W-1:0]        deg;
    logic [MIN_W-1:0]        mins;
    logic [FRAC_ACC_W-1:0]   frac;
    logic [FCNT_W-1:0]       fcnt;
  } nctd_job_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } nctd_back_stat_t;

endpackage

// File: src/nctd_front.sv
// nctd_front: character parser, accumulates degrees, minutes and fraction digits
// and emits one classified job per coordinate text
// depends on nctd_pkg
module nctd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [nctd_pkg::CHAR_W-1:0]       char_code_i,
  input  logic                              is_last_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              job_valid_o,
  output nctd_pkg::nctd_job_t               job_o,
  input  logic                              job_ready_i
);

  logic                                 point_q, point_d;
  logic                                 frac_end_q, frac_end_d;
  logic                                 malf_q, malf_d;
  logic [nctd_pkg::ICNT_W-1:0]          icnt_q, icnt_d;
  logic [nctd_pkg::FCNT_W-1:0]          fcnt_q, fcnt_d;
  logic [nctd_pkg::DEG_W-1:0]           deg_q, deg_d;
  logic [nctd_pkg::DIGIT_W-1:0]         hi_q, hi_d;
  logic [nctd_pkg::DIGIT_W-1:0]         lo_q, lo_d;
  logic [nctd_pkg::FRAC_ACC_W-1:0]      frac_q, frac_d;
  logic                                 is_digit;
  logic [nctd_pkg::DIGIT_W-1:0]         digit;
  logic                                 accept;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  always_comb begin
    point_d    = point_q;
    frac_end_d = frac_end_q;
    malf_d     = malf_q;
    icnt_d     = icnt_q;
    fcnt_d     = fcnt_q;
    deg_d      = deg_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    frac_d     = frac_q;
    is_digit   = (char_code_i >= nctd_pkg::CHAR_ZERO) && (char_code_i <= nctd_pkg::CHAR_NINE);
    digit      = char_code_i[nctd_pkg::DIGIT_W-1:0];

    if (!point_q) begin
      priority if (char_code_i == nctd_pkg::CHAR_POINT) begin
        point_d = 1'b1;
      end else if (!is_digit || malf_q
                   || (icnt_q >= nctd_pkg::ICNT_W'(nctd_pkg::MAX_INT_DIGITS))) begin
        // a stray character or a digit too many spoils the integer part for good
        malf_d = 1'b1;
      end else begin
        // the two newest digits stay as minutes, older ones shift into degrees
        deg_d  = nctd_pkg::DEG_W'({deg_q, 3'b000} + {deg_q, 1'b0}
                                  + (nctd_pkg::DEG_W + 3)'(hi_q));
        hi_d   = lo_q;
        lo_d   = digit;
        icnt_d = icnt_q + nctd_pkg::ICNT_W'(1);
      end
    end else if (!frac_end_q) begin
      if (!is_digit) begin
        frac_end_d = 1'b1;
      end else if (fcnt_q < nctd_pkg::FCNT_W'(nctd_pkg::MAX_FRAC_DIGITS)) begin
        frac_d = nctd_pkg::FRAC_ACC_W'({frac_q, 3'b000} + {frac_q, 1'b0}
                                       + (nctd_pkg::FRAC_ACC_W + 3)'(digit));
        fcnt_d = fcnt_q + nctd_pkg::FCNT_W'(1);
      end
    end

    job_valid_o = in_valid_i && is_last_i;
    job_o.neg   = (char_code_i == nctd_pkg::CHAR_SOUTH) || (char_code_i == nctd_pkg::CHAR_WEST);
    job_o.deg   = deg_d;
    job_o.mins  = nctd_pkg::MIN_W'({hi_d, 3'b000}) + nctd_pkg::MIN_W'({hi_d, 1'b0})
                  + nctd_pkg::MIN_W'(lo_d);
    job_o.frac  = frac_d;
    job_o.fcnt  = fcnt_d;
    priority if (!point_d) begin
      job_o.status = nctd_pkg::ST_NO_POINT;
    end else if (malf_d) begin
      job_o.status = nctd_pkg::ST_MALFORMED;
    end else if (icnt_d < nctd_pkg::ICNT_W'(nctd_pkg::MIN_INT_DIGITS)) begin
      job_o.status = nctd_pkg::ST_FEW_DIGITS;
    end else begin
      job_o.status = nctd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q    <= 1'b0;
      frac_end_q <= 1'b0;
      malf_q     <= 1'b0;
      icnt_q     <= '0;
      fcnt_q     <= '0;
      deg_q      <= '0;
      hi_q       <= '0;
      lo_q       <= '0;
      frac_q     <= '0;
    end else if (accept) begin
      if (is_last_i) begin
        // text complete, start afresh
        point_q    <= 1'b0;
        frac_end_q <= 1'b0;
        malf_q     <= 1'b0;
        icnt_q     <= '0;
        fcnt_q     <= '0;
        deg_q      <= '0;
        hi_q       <= '0;
        lo_q       <= '0;
        frac_q     <= '0;
      end else begin
        point_q    <= point_d;
        frac_end_q <= frac_end_d;
        malf_q     <= malf_d;
        icnt_q     <= icnt_d;
        fcnt_q     <= fcnt_d;
        deg_q      <= deg_d;
        hi_q       <= hi_d;
        lo_q       <= lo_d;
        frac_q     <= frac_d;
      end
    end
  end

endmodule

// File: src/nctd_queue.sv
// nctd_queue: short job queue between the parser and the converter
// depends on nctd_pkg
module nctd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  nctd_pkg::nctd_job_t  push_job_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output nctd_pkg::nctd_job_t  pop_job_o
);

  nctd_pkg::nctd_job_t             mem_q [nctd_pkg::QUEUE_DEPTH];
  logic [nctd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [nctd_pkg::QCNT_W-1:0]     count_q;
  logic                            push, pop;

  assign push_ready_o = count_q != nctd_pkg::QCNT_W'(nctd_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  function automatic logic [nctd_pkg::QPTR_W-1:0] ptr_next(
    input logic [nctd_pkg::QPTR_W-1:0] p
  );
    if (p == nctd_pkg::QPTR_W'(nctd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + nctd_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + nctd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - nctd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/nctd_back.sv
// nctd_back: minutes-to-degrees converter, bit-serial divide by 60 * 10^k,
// rounding, sign and saturation, with the result register
// depends on nctd_pkg
module nctd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  nctd_pkg::nctd_job_t               job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [nctd_pkg::OUT_W-1:0] degrees_fixed_o,
  output logic [1:0]                        status_o,
  output nctd_pkg::nctd_back_stat_t         stat_o
);

  nctd_pkg::nctd_bk_state_e            state_q, state_d;
  nctd_pkg::nctd_job_t                 job_q;
  logic [nctd_pkg::NUM_W-1:0]          num_q;
  logic [nctd_pkg::DEN_W-1:0]          den_q;
  logic                                whole_q;
  logic [nctd_pkg::DEN_W-1:0]          rem_q;
  logic [nctd_pkg::FRAC_BITS-1:0]      bits_q;
  logic [nctd_pkg::ITER_W-1:0]         iter_q;
  logic [nctd_pkg::MAG_W-1:0]          mag_q, mag_d;
  logic                                out_valid_q;
  logic [nctd_pkg::OUT_W-1:0]          out_deg_q;
  nctd_pkg::nctd_status_e              out_status_q;

  logic                                out_free;
  logic                                out_wr_err, out_wr_ok;
  logic [nctd_pkg::NUM_W-1:0]          scale;
  logic [nctd_pkg::DEN_W-1:0]          den_lk;
  logic                                setup_whole;
  logic [nctd_pkg::DEN_W:0]            rem_x2;
  logic                                step_bit;
  logic [nctd_pkg::DEN_W-1:0]          step_rem;
  logic                                rnd;
  logic [nctd_pkg::DEG_W+1:0]          int_part;
  longint unsigned                     mag64;
  logic [nctd_pkg::OUT_W-1:0]          sat;
  logic [nctd_pkg::OUT_W-1:0]          final_val;

  assign out_free = !out_valid_q || out_ready_i;

  // control
  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    out_wr_err  = 1'b0;
    out_wr_ok   = 1'b0;
    unique case (state_q)
      nctd_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.status != nctd_pkg::ST_OK) begin
            // error results skip the divider
            job_ready_o = out_free;
            out_wr_err  = out_free;
          end else begin
            job_ready_o = 1'b1;
            state_d     = nctd_pkg::BK_LOAD;
          end
        end
      end
      nctd_pkg::BK_LOAD:   state_d = nctd_pkg::BK_SETUP;
      nctd_pkg::BK_SETUP:  state_d = nctd_pkg::BK_DIVIDE;
      nctd_pkg::BK_DIVIDE: begin
        if (iter_q == nctd_pkg::ITER_W'(nctd_pkg::FRAC_BITS - 1)) begin
          state_d = nctd_pkg::BK_ROUND;
        end
      end
      nctd_pkg::BK_ROUND:  state_d = nctd_pkg::BK_FINISH;
      nctd_pkg::BK_FINISH: begin
        if (out_free) begin
          out_wr_ok = 1'b1;
          state_d   = nctd_pkg::BK_IDLE;
        end
      end
      default: state_d = nctd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nctd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_wr_err || out_wr_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_comb begin
    scale  = '0;
    den_lk = '0;
    for (int k = 0; k <= nctd_pkg::MAX_FRAC_DIGITS; k++) begin
      if (nctd_pkg::FCNT_W'(k) == job_q.fcnt) begin
        scale  = nctd_pkg::NUM_W'(nctd_pkg::pow10(k));
        den_lk = nctd_pkg::DEN_W'(nctd_pkg::MINS_PER_DEG * nctd_pkg::pow10(k));
      end
    end

    setup_whole = num_q >= nctd_pkg::NUM_W'(den_q);

    rem_x2   = {rem_q, 1'b0};
    step_bit = rem_x2 >= {1'b0, den_q};
    step_rem = step_bit ? nctd_pkg::DEN_W'(rem_x2 - {1'b0, den_q})
                        : nctd_pkg::DEN_W'(rem_x2);

    // round half up on the remainder left after the last quotient bit
    rnd      = rem_x2 >= {1'b0, den_q};
    int_part = (nctd_pkg::DEG_W + 2)'(job_q.deg) + (nctd_pkg::DEG_W + 2)'(whole_q);
    mag_d    = {int_part, bits_q} + nctd_pkg::MAG_W'(rnd);

    mag64 = 64'(mag_q);
    if (job_q.neg) begin
      sat       = (mag64 > nctd_pkg::NEG_LIMIT) ? nctd_pkg::OUT_W'(nctd_pkg::NEG_LIMIT)
                                                : nctd_pkg::OUT_W'(mag64);
      final_val = ~sat + nctd_pkg::OUT_W'(1);
    end else begin
      sat       = (mag64 > nctd_pkg::POS_LIMIT) ? nctd_pkg::OUT_W'(nctd_pkg::POS_LIMIT)
                                                : nctd_pkg::OUT_W'(mag64);
      final_val = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
    unique case (state_q)
      nctd_pkg::BK_LOAD: begin
        num_q <= nctd_pkg::NUM_W'(nctd_pkg::NUM_W'(job_q.mins) * scale)
                 + nctd_pkg::NUM_W'(job_q.frac);
        den_q <= den_lk;
      end
      nctd_pkg::BK_SETUP: begin
        whole_q <= setup_whole;
        rem_q   <= setup_whole ? nctd_pkg::DEN_W'(num_q - nctd_pkg::NUM_W'(den_q))
                               : nctd_pkg::DEN_W'(num_q);
        bits_q  <= '0;
        iter_q  <= '0;
      end
      nctd_pkg::BK_DIVIDE: begin
        rem_q  <= step_rem;
        bits_q <= {bits_q[nctd_pkg::FRAC_BITS-2:0], step_bit};
        iter_q <= iter_q + nctd_pkg::ITER_W'(1);
      end
      nctd_pkg::BK_ROUND: begin
        mag_q <= mag_d;
      end
      default: begin
      end
    endcase
    if (out_wr_err) begin
      out_deg_q    <= '0;
      out_status_q <= job_i.status;
    end else if (out_wr_ok) begin
      out_deg_q    <= final_val;
      out_status_q <= nctd_pkg::ST_OK;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign degrees_fixed_o = out_deg_q;
  assign status_o        = out_status_q;
  assign stat_o.busy     = state_q != nctd_pkg::BK_IDLE;
  assign stat_o.finish   = out_wr_ok;

endmodule

// File: src/nmea_coordinate_to_degrees.sv
// channel  | handshake                 | payload
// input    | in_valid_i / in_ready_o   | char_code_i, is_last_i
// result   | out_valid_o / out_ready_i | degrees_fixed_o, status_o
//
// one character accepted per cycle; the parser keeps taking characters while
// the converter works, as long as the two-entry job queue has room
// a well-formed coordinate goes through the converter steps in order (take from queue,
// load, setup, 24 quotient bits of the shift-subtract divider, round, finish), and the
// converter takes no new job until its result is written; error results skip the divider
// reset clears parser state, queue pointers and converter control at once
// a stalled result holds the converter in its finish step
//
// top level: nctd_front -> nctd_queue -> nctd_back, depends on nctd_pkg
module nmea_coordinate_to_degrees (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        char_code_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [34:0]                degrees_fixed_o,
  output logic [1:0]                        status_o
);

  logic                        q_push_valid, q_push_ready;
  nctd_pkg::nctd_job_t         q_push_job;
  logic                        q_pop_valid, q_pop_ready;
  nctd_pkg::nctd_job_t         q_pop_job;
  nctd_pkg::nctd_back_stat_t   back_stat;

  nctd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .job_valid_o (q_push_valid),
    .job_o       (q_push_job),
    .job_ready_i (q_push_ready)
  );

  nctd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_job_i   (q_push_job),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_job_o    (q_pop_job)
  );

  nctd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_pop_valid),
    .job_ready_o     (q_pop_ready),
    .job_i           (q_pop_job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .degrees_fixed_o (degrees_fixed_o),
    .status_o        (status_o),
    .stat_o          (back_stat)
  );

  // error results always carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != nctd_pkg::ST_OK) |-> degrees_fixed_o == '0)
    else $error("error result with non-zero degrees");

  // the converter takes no new job while a conversion is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> !q_pop_ready)
    else $error("job taken while converter busy");

  // a fresh result comes only from an error job or a finished conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(q_pop_valid && q_pop_ready && (q_pop_job.status != nctd_pkg::ST_OK))
      || $past(back_stat.finish))
    else $error("result appeared without a source");

endmodule

// File: verif/tb_nmea_coordinate_to_degrees.sv
// tb_nmea_coordinate_to_degrees: self-checking testbench for the nmea coordinate converter
// drives character transactions, predicts decimal degrees in a scoreboard class
// depends on nctd_pkg and nmea_coordinate_to_degrees
module tb_nmea_coordinate_to_degrees;
  timeunit 1ns;
  timeprecision 1ps;

  import nctd_pkg::*;

  localparam time CLK_PERIOD     = 8ns;
  localparam int  RESET_CYCLES   = 10;
  localparam int  RANDOM_CHARS   = 900;
  localparam int  IDLE_PCT       = 15;
  localparam int  QUIET_START    = 300;
  localparam int  QUIET_END      = 500;
  localparam int  DRAIN_CYCLES   = 64;
  localparam int  WATCHDOG_LIMIT = 3000;
  localparam int  REPORT_LIMIT   = 10;

  localparam logic [CHAR_W-1:0] CHAR_NORTH = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_EAST  = 8'h45;

  typedef struct {
    logic signed [OUT_W-1:0] degrees;
    nctd_status_e            status;
  } coord_result_t;

  class coord_scoreboard;
    logic [16:0]   int_acc;
    logic [2:0]    int_cnt;
    bit            pt_seen;
    logic [23:0]   frac_acc;
    logic [2:0]    frac_cnt;
    bit            frac_done;
    bit            bad_int;
    coord_result_t pending_q[$];
    int            errors;
    int            checked;
    int            status_seen[4];

    function void clear_text();
      int_acc   = '0;
      int_cnt   = '0;
      pt_seen   = 1'b0;
      frac_acc  = '0;
      frac_cnt  = '0;
      frac_done = 1'b0;
      bad_int   = 1'b0;
    endfunction

    function new();
      clear_text();
      errors  = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    // degrees plus minutes / 60, rounded half up to the fraction step
    function longint unsigned fixed_magnitude();
      longint unsigned whole_deg;
      longint unsigned mins;
      longint unsigned scale;
      longint unsigned num;
      longint unsigned den;
      longint unsigned quot;
      longint unsigned rem;
      longint unsigned bits;
      whole_deg = int_acc / 100;
      mins      = int_acc % 100;
      scale     = 1;
      for (int i = 0; i < frac_cnt; i++) scale = scale * 10;
      num  = mins * scale + frac_acc;
      den  = MINS_PER_DEG * scale;
      quot = num / den;
      rem  = num % den;
      bits = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem  = rem << 1;
        bits = bits << 1;
        if (rem >= den) begin
          rem  = rem - den;
          bits = bits | 64'd1;
        end
      end
      if ((rem << 1) >= den) bits = bits + 1;
      return ((whole_deg + quot) << FRAC_BITS) + bits;
    endfunction

    function void record_char(logic [CHAR_W-1:0] c, logic last);
      bit              digit;
      longint unsigned mag;
      coord_result_t   want;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (!pt_seen) begin
        if (c == CHAR_POINT) begin
          pt_seen = 1'b1;
        end else if (!digit) begin
          bad_int = 1'b1;
        end else if (!bad_int) begin
          if (int_cnt >= MAX_INT_DIGITS) begin
            bad_int = 1'b1;
          end else begin
            int_acc = int_acc * 10 + 17'(c - CHAR_ZERO);
            int_cnt++;
          end
        end
      end else if (!frac_done) begin
        if (!digit) begin
          frac_done = 1'b1;
        end else if (frac_cnt < MAX_FRAC_DIGITS) begin
          frac_acc = frac_acc * 10 + 24'(c - CHAR_ZERO);
          frac_cnt++;
        end
      end
      if (!last) return;

      if (!pt_seen) want.status = ST_NO_POINT;
      else if (bad_int) want.status = ST_MALFORMED;
      else if (int_cnt < MIN_INT_DIGITS) want.status = ST_FEW_DIGITS;
      else want.status = ST_OK;

      want.degrees = '0;
      if (want.status == ST_OK) begin
        mag = fixed_magnitude();
        // hemisphere is decided by the final character alone
        if (c == CHAR_SOUTH || c == CHAR_WEST) begin
          if (mag > NEG_LIMIT) mag = NEG_LIMIT;
          want.degrees = OUT_W'(64'd0 - mag);
        end else begin
          if (mag > POS_LIMIT) mag = POS_LIMIT;
          want.degrees = OUT_W'(mag);
        end
      end
      status_seen[want.status]++;
      pending_q.push_back(want);
      clear_text();
    endfunction

    function void check_result(logic signed [OUT_W-1:0] degrees, logic [1:0] status);
      coord_result_t want;
      if (pending_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: degrees %0d status %0d",
                             degrees, status));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (degrees !== want.degrees || status !== want.status) begin
        note_error($sformatf("mismatch on result %0d: expected degrees %0d status %0d, got degrees %0d status %0d",
                             checked, want.degrees, want.status, degrees, status));
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [CHAR_W-1:0]       char_code_i;
  logic                    is_last_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [OUT_W-1:0] degrees_fixed_o;
  logic [1:0]              status_o;

  coord_scoreboard   sb;
  logic [CHAR_W-1:0] text_q[$];
  int                in_idle_pct;
  int                out_idle_pct;
  int                chars_sent;
  int                texts_sent;
  int                quiet_cycles;
  int                random_start;

  nmea_coordinate_to_degrees dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .degrees_fixed_o(degrees_fixed_o),
    .status_o       (status_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // result side: check each accepted transaction, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(degrees_fixed_o, status_o);
    end
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // called just after a rising edge; one valid assignment per edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.record_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic build_random_text();
    int kind;
    int n_int;
    int n_frac;
    int hemi;
    kind = $urandom_range(99);
    if (kind < 82) begin
      // mostly well-formed, with the odd short or long integer part
      n_int = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : $urandom_range(2, 5);
      repeat (n_int) text_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
      if ($urandom_range(19) != 0) text_q.push_back(CHAR_POINT);
      n_frac = $urandom_range(0, 9);
      repeat (n_frac) text_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
      hemi = $urandom_range(5);
      case (hemi)
        1: text_q.push_back(CHAR_NORTH);
        2: text_q.push_back(CHAR_SOUTH);
        3: text_q.push_back(CHAR_EAST);
        4: text_q.push_back(CHAR_WEST);
        5: text_q.push_back(CHAR_W'($urandom_range(255)));
        default: ;
      endcase
      if (text_q.size() != 0 && $urandom_range(9) == 0) begin
        text_q[$urandom_range(text_q.size() - 1)] = CHAR_W'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(1) == 0) begin
          text_q.push_back(CHAR_W'($urandom_range(255)));
        end else if ($urandom_range(10) == 10) begin
          text_q.push_back(CHAR_POINT);
        end else begin
          text_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
        end
      end
    end
    if (text_q.size() == 0) text_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_code_i  = '0;
    is_last_i    = 1'b0;
    out_ready_i  = 1'b0;
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    chars_sent   = 0;
    texts_sent   = 0;
    quiet_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest integer part, fraction digits past the bound, western hemisphere
    push_str("99999.99999999W");
    send_text();
    // nul and all-ones characters with no point
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    // point with no integer digits, fraction ended by the hemisphere letter
    push_str(".S");
    send_text();
    // one integer digit too many
    push_str("123456.");
    send_text();
    // second point ends the fraction and is the final character
    push_str("00..");
    send_text();

    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      if (chars_sent - random_start >= QUIET_START && chars_sent - random_start < QUIET_END) begin
        in_idle_pct = 0;
      end else begin
        in_idle_pct = IDLE_PCT;
      end
      out_idle_pct = in_idle_pct;
      build_random_text();
      send_text();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d characters in %0d texts, checked %0d results", chars_sent, texts_sent,
             sb.checked);
    $display("status mix: %0d ok, %0d no point, %0d short integer, %0d malformed",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_POINT],
             sb.status_seen[ST_FEW_DIGITS], sb.status_seen[ST_MALFORMED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
